>>> sv/grpr_pkg.sv
// Shared types and constants for the glyph row pixel rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package grpr_pkg;

  // Default geometry of the glyph store
  localparam int GlyphRowsDef = 16;
  localparam int CharCountDef = 256;

  // Configuration register widths and reset values
  localparam int CfgDataW     = 16;
  localparam int CfgAddrW     = 2;
  localparam logic [2:0]  BppReset    = 3'd4;
  localparam logic [15:0] PitchReset  = 16'd4096;
  localparam logic [1:0]  ScaleReset  = 2'd1;
  localparam logic [3:0]  GwidthReset = 4'd8;

  // Register indexes on the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    CFG_BPP    = 2'd0,
    CFG_PITCH  = 2'd1,
    CFG_SCALE  = 2'd2,
    CFG_GWIDTH = 2'd3
  } cfg_reg_e;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_write;   // write row_bits into the store
    logic draw_accept;  // latch draw fields, read the store
    logic scan;         // step the column / sub-pixel counters
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_range;       // code and row address a store entry
    logic pattern_empty;  // nothing to draw for the looked-up row
    logic last_pixel;     // final pixel emitted this cycle
    logic pipe_busy;      // offset pipeline still holds pixels
  } dp_status_t;

endpackage
`default_nettype wire

>>> sv/grpr_ctrl.sv
// Controller state machine of the glyph row pixel rasterizer.
`timescale 1ns / 1ps
`default_nettype none
module grpr_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire logic                   req_type_i,
  input  wire grpr_pkg::dp_status_t   status_i,
  output grpr_pkg::ctrl_cmd_t         cmd_o,
  output logic                        busy
);
  import grpr_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = (state_q == ST_IDLE) && start && status_i.in_range;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_DRAW)) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = status_i.pattern_empty ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.last_pixel) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.load_write  = accept && (req_type_i == REQ_LOAD);
    cmd_o.draw_accept = accept && (req_type_i == REQ_DRAW);
    cmd_o.scan        = (state_q == ST_SCAN);
    busy              = (state_q != ST_IDLE);
  end

endmodule
`default_nettype wire

>>> sv/grpr_datapath.sv
// Datapath: config registers, glyph store, pixel counters and offset pipeline.
`timescale 1ns / 1ps
`default_nettype none
module grpr_datapath #(
  parameter int GLYPH_ROWS = grpr_pkg::GlyphRowsDef,
  parameter int CHAR_COUNT = grpr_pkg::CharCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [grpr_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [grpr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic [7:0]                    character_code_i,
  input  wire logic [3:0]                    glyph_row_i,
  input  wire logic [7:0]                    row_bits_i,
  input  wire logic [15:0]                   origin_x_i,
  input  wire logic [15:0]                   origin_y_i,
  input  wire logic [23:0]                   draw_color_i,
  input  wire grpr_pkg::ctrl_cmd_t           cmd_i,
  output grpr_pkg::dp_status_t               status_o,
  output logic                               result_strobe_o,
  output logic [32:0]                        byte_offset_o,
  output logic [23:0]                        pixel_color_o,
  output logic                               last_o
);
  import grpr_pkg::*;

  localparam int StoreDepth = CHAR_COUNT * GLYPH_ROWS;
  localparam int IdxW       = $clog2(StoreDepth);

  // Configuration registers
  logic [2:0]  bpp_q;
  logic [15:0] pitch_q;
  logic [1:0]  scale_q;
  logic [3:0]  gwidth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BppReset;
      pitch_q  <= PitchReset;
      scale_q  <= ScaleReset;
      gwidth_q <= GwidthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_BPP:    bpp_q    <= cfg_wdata_i[2:0];
        CFG_PITCH:  pitch_q  <= cfg_wdata_i[15:0];
        CFG_SCALE:  scale_q  <= cfg_wdata_i[1:0];
        CFG_GWIDTH: gwidth_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective scale (3 saturates to 2) and column mask
  logic [1:0] sc;
  logic [7:0] wmask;
  assign sc    = (scale_q == 2'd3) ? 2'd2 : scale_q;
  assign wmask = (gwidth_q >= 4'd8) ? 8'hFF : 8'((9'd1 << gwidth_q) - 9'd1);

  // Store address and range check
  logic            in_range;
  logic [IdxW-1:0] idx;
  assign in_range = (int'(character_code_i) < CHAR_COUNT) &&
                    (int'(glyph_row_i) < GLYPH_ROWS);
  assign idx      = IdxW'(int'(character_code_i) * GLYPH_ROWS + int'(glyph_row_i));

  // Glyph store, contents undefined until loaded
  logic [7:0] store_mem [StoreDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write) store_mem[idx] <= row_bits_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_accept) rdata_q <= store_mem[idx];
  end

  // Draw word fields held for the whole item
  logic [15:0] ox_q, oy_q;
  logic [3:0]  row_q;
  logic [23:0] color_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_accept) begin
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      row_q   <= glyph_row_i;
      color_q <= draw_color_i;
    end
  end

  // Column and sub-pixel counters
  logic [2:0] col_q, col_d;
  logic       sx_q, sx_d, sy_q, sy_d;
  logic [7:0] pattern, above;
  logic       bit_set, sx_end, sy_end, emit, emit_last;

  assign pattern   = rdata_q & wmask;
  assign above     = pattern & ~((8'd2 << col_q) - 8'd1);
  assign bit_set   = pattern[col_q];
  assign sx_end    = (sx_q == sc[1]);
  assign sy_end    = (sy_q == sc[1]);
  assign emit      = cmd_i.scan && bit_set;
  assign emit_last = emit && sx_end && sy_end && (above == 8'd0);

  always_comb begin
    col_d = col_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    if (cmd_i.draw_accept) begin
      col_d = 3'd0;
      sx_d  = 1'b0;
      sy_d  = 1'b0;
    end else if (cmd_i.scan) begin
      if (!bit_set) begin
        col_d = col_q + 3'd1;
      end else if (!sx_end) begin
        sx_d = 1'b1;
      end else begin
        sx_d = 1'b0;
        if (sy_end) begin
          sy_d  = 1'b0;
          col_d = col_q + 3'd1;
        end else begin
          sy_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 3'd0;
      sx_q  <= 1'b0;
      sy_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
    end
  end

  // Stage A: pixel coordinates
  logic [3:0]  colsc;
  logic [4:0]  rowsc;
  logic [16:0] px_d, py_d, px_a_q, py_a_q;
  logic        vld_a_q, last_a_q;

  assign colsc = (sc == 2'd2) ? {col_q, 1'b0} : {1'b0, col_q};
  assign rowsc = (sc == 2'd2) ? {row_q, 1'b0} : {1'b0, row_q};
  assign px_d  = {1'b0, ox_q} + 17'(colsc) + 17'(sx_q);
  assign py_d  = {1'b0, oy_q} + 17'(rowsc) + 17'(sy_q);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_a_q <= px_d;
      py_a_q <= py_d;
    end
  end

  // Stage B: products
  logic [19:0] prodx_q;
  logic [32:0] prody_q;
  logic        vld_b_q, last_b_q;

  always_ff @(posedge clk_i) begin
    if (vld_a_q) begin
      prodx_q <= 20'(px_a_q) * 20'(bpp_q);
      prody_q <= 33'(py_a_q) * 33'(pitch_q);
    end
  end

  // Stage C: output word
  always_ff @(posedge clk_i) begin
    if (vld_b_q) byte_offset_o <= 33'(prodx_q) + prody_q;
  end

  // Pipeline valid and last flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q         <= 1'b0;
      last_a_q        <= 1'b0;
      vld_b_q         <= 1'b0;
      last_b_q        <= 1'b0;
      result_strobe_o <= 1'b0;
      last_o          <= 1'b0;
    end else begin
      vld_a_q         <= emit;
      last_a_q        <= emit_last;
      vld_b_q         <= vld_a_q;
      last_b_q        <= vld_a_q && last_a_q;
      result_strobe_o <= vld_b_q;
      last_o          <= vld_b_q && last_b_q;
    end
  end

  assign pixel_color_o = color_q;

  // Status to controller
  always_comb begin
    status_o.in_range      = in_range;
    status_o.pattern_empty = (pattern == 8'd0) || (sc == 2'd0);
    status_o.last_pixel    = emit_last;
    status_o.pipe_busy     = vld_a_q || vld_b_q;
  end

endmodule
`default_nettype wire

>>> sv/glyph_row_pixel_rasterizer.sv
// Top level of the glyph row pixel rasterizer: controller plus datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------
//  request   | start / busy               | req_type_i, character_code_i,
//            |                            | glyph_row_i, row_bits_i, origin_x_i,
//            |                            | origin_y_i, draw_color_i
//  result    | result_strobe_o (1 cycle)  | byte_offset_o, pixel_color_o, last_o
//  config    | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
//
// A load word is written into the glyph store at its accept edge; busy stays low.
// A draw word holds busy through a lookup state, where an empty row or scale 0
// ends. Otherwise it scans the columns up to the last set one (scale*scale pixel
// words for a set column, scale 3 acting as 2), then drains the offset pipeline
// (coordinate, multiply, add); busy drops after the last result. A set column
// thus delivers one pixel word per cycle. Reset clears control and config; the
// store is not cleared. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none
module glyph_row_pixel_rasterizer #(
  parameter int GLYPH_ROWS = grpr_pkg::GlyphRowsDef,
  parameter int CHAR_COUNT = grpr_pkg::CharCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [grpr_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [grpr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type_i,
  input  wire logic [7:0]                    character_code_i,
  input  wire logic [3:0]                    glyph_row_i,
  input  wire logic [7:0]                    row_bits_i,
  input  wire logic [15:0]                   origin_x_i,
  input  wire logic [15:0]                   origin_y_i,
  input  wire logic [23:0]                   draw_color_i,
  output logic                               result_strobe_o,
  output logic [32:0]                        byte_offset_o,
  output logic [23:0]                        pixel_color_o,
  output logic                               last_o
);
  import grpr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  grpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  grpr_datapath #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .CHAR_COUNT (CHAR_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .character_code_i (character_code_i),
    .glyph_row_i      (glyph_row_i),
    .row_bits_i       (row_bits_i),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .draw_color_i     (draw_color_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .result_strobe_o  (result_strobe_o),
    .byte_offset_o    (byte_offset_o),
    .pixel_color_o    (pixel_color_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

>>> sv/grpr_checker.sv
// Port-level checks of the glyph row pixel rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module grpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        busy,
  input wire logic        result_strobe_o,
  input wire logic        last_o,
  input wire logic [23:0] pixel_color_o
);

  // Results only appear inside a busy draw
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> busy)
    else $error("result word outside busy");

  // Last only marks a delivered word
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_strobe_o)
    else $error("last without result word");

  // Block goes idle right after the last word
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_o) |=> !busy)
    else $error("busy after last word");

  // Color holds for the whole draw
  a_color_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> $stable(pixel_color_o))
    else $error("color changed during draw");

endmodule

bind glyph_row_pixel_rasterizer grpr_checker u_grpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .last_o          (last_o),
  .pixel_color_o   (pixel_color_o)
);
`default_nettype wire

>>> tb/glyph_row_pixel_rasterizer_test.sv
// Self-checking testbench for the glyph row pixel rasterizer.
`timescale 1ns / 1ps
module glyph_row_pixel_rasterizer_test;
  import grpr_pkg::*;

  localparam int HalfPeriod    = 6;
  localparam int ResetCycles   = 12;
  localparam int DrainCycles   = 48;
  localparam int CycleLimit    = 200000;
  localparam int RandomPhases  = 8;
  localparam int WordsPerPhase = 27;

  // One request word and one pixel word
  typedef struct {
    logic        kind;
    logic [7:0]  code;
    logic [3:0]  row;
    logic [7:0]  row_bits;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [23:0] color;
  } glyph_req_t;

  typedef struct {
    logic [32:0] offset;
    logic [23:0] color;
    logic        last;
  } pixel_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                start;
  logic                busy;
  logic                req_type_i;
  logic [7:0]          character_code_i;
  logic [3:0]          glyph_row_i;
  logic [7:0]          row_bits_i;
  logic [15:0]         origin_x_i;
  logic [15:0]         origin_y_i;
  logic [23:0]         draw_color_i;
  logic                result_strobe_o;
  logic [32:0]         byte_offset_o;
  logic [23:0]         pixel_color_o;
  logic                last_o;

  // Mirror of the block: register copies, glyph store copy, expected pixels
  logic [2:0]  bpp_cfg   = BppReset;
  logic [15:0] pitch_cfg = PitchReset;
  logic [1:0]  scale_cfg = ScaleReset;
  logic [3:0]  width_cfg = GwidthReset;
  logic [7:0]  glyph_copy [0:4095];
  bit          row_loaded [0:4095];
  int unsigned loaded_keys[$];
  pixel_word_t pending_pixels[$];

  int unsigned burst_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  glyph_row_pixel_rasterizer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .character_code_i (character_code_i),
    .glyph_row_i      (glyph_row_i),
    .row_bits_i       (row_bits_i),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .draw_color_i     (draw_color_i),
    .result_strobe_o  (result_strobe_o),
    .byte_offset_o    (byte_offset_o),
    .pixel_color_o    (pixel_color_o),
    .last_o           (last_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Compare each pixel word with the oldest expected one
  always @(posedge clk_i) begin
    pixel_word_t want;
    if (rst_ni === 1'b1 && result_strobe_o === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word: byte_offset %h", byte_offset_o);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (byte_offset_o !== want.offset) begin
          $error("byte_offset: expected %h, got %h", want.offset, byte_offset_o);
          fail_count++;
        end
        if (pixel_color_o !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, pixel_color_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  function automatic glyph_req_t make_req(input logic kind, input logic [7:0] code,
                                          input logic [3:0] row, input logic [7:0] row_bits,
                                          input logic [15:0] ox, input logic [15:0] oy,
                                          input logic [23:0] color);
    glyph_req_t r;
    r.kind     = kind;
    r.code     = code;
    r.row      = row;
    r.row_bits = row_bits;
    r.ox       = ox;
    r.oy       = oy;
    r.color    = color;
    return r;
  endfunction

  // Store a loaded row, or expand a drawn row into its pixel writes
  task automatic rasterize_row(input glyph_req_t r);
    int unsigned     key;
    int unsigned     sc;
    int unsigned     w;
    logic [7:0]      pattern;
    longint unsigned px;
    longint unsigned py;
    longint unsigned off;
    pixel_word_t     p;
    pixel_word_t     row_words[$];
    key = 32'({r.code, r.row});
    if (r.kind == REQ_LOAD) begin
      glyph_copy[key] = r.row_bits;
      if (!row_loaded[key]) begin
        row_loaded[key] = 1'b1;
        loaded_keys.push_back(key);
      end
      return;
    end
    // scale three acts as two, widths above eight act as eight
    sc = (scale_cfg > 2) ? 2 : scale_cfg;
    w  = (width_cfg > 8) ? 8 : width_cfg;
    pattern = glyph_copy[key];
    for (int col = 0; col < w; col++) begin
      if (pattern[col]) begin
        for (int sy = 0; sy < sc; sy++) begin
          for (int sx = 0; sx < sc; sx++) begin
            px  = r.ox;
            px  = px + col * sc + sx;
            py  = r.oy;
            py  = py + r.row * sc + sy;
            off = px * bpp_cfg + py * pitch_cfg;
            p.offset = off[32:0];
            p.color  = r.color;
            p.last   = 1'b0;
            row_words.push_back(p);
          end
        end
      end
    end
    foreach (row_words[i]) begin
      p = row_words[i];
      p.last = (i == row_words.size() - 1);
      pending_pixels.push_back(p);
    end
  endtask

  // Drive one word, with a random gap when a burst ends, and wait for accept
  task automatic send_word(input glyph_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 2))
        0: gap = 0;
        1: gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 45);
      endcase
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    start            <= 1'b1;
    req_type_i       <= r.kind;
    character_code_i <= r.code;
    glyph_row_i      <= r.row;
    row_bits_i       <= r.row_bits;
    origin_x_i       <= r.ox;
    origin_y_i       <= r.oy;
    draw_color_i     <= r.color;
    do @(posedge clk_i); while (busy !== 1'b0);
    rasterize_row(r);
    burst_left--;
  endtask

  // Stop sending, let every expected pixel arrive, then let the block go idle
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BPP:    bpp_cfg   = val[2:0];
      CFG_PITCH:  pitch_cfg = val;
      CFG_SCALE:  scale_cfg = val[1:0];
      CFG_GWIDTH: width_cfg = val[3:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [2:0] bpp, input logic [15:0] pitch,
                              input logic [1:0] scale, input logic [3:0] width);
    settle();
    write_reg(CFG_BPP, CfgDataW'(bpp));
    write_reg(CFG_PITCH, CfgDataW'(pitch));
    write_reg(CFG_SCALE, CfgDataW'(scale));
    write_reg(CFG_GWIDTH, CfgDataW'(width));
  endtask

  // Reset geometry: full, sparse and empty rows at the field extremes
  task automatic test_default_geometry();
    send_word(make_req(REQ_LOAD, 8'd0, 4'd0, 8'hFF, 16'h0000, 16'h0000, 24'h000000));
    send_word(make_req(REQ_LOAD, 8'd255, 4'd15, 8'h81, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
    send_word(make_req(REQ_LOAD, 8'h55, 4'd5, 8'h00, 16'h1234, 16'h4321, 24'h5A5A5A));
    send_word(make_req(REQ_LOAD, 8'h3C, 4'd7, 8'h01, 16'h0000, 16'h0000, 24'h000000));
    send_word(make_req(REQ_DRAW, 8'd0, 4'd0, 8'h00, 16'h0000, 16'h0000, 24'h000000));
    send_word(make_req(REQ_DRAW, 8'd255, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
    send_word(make_req(REQ_DRAW, 8'h55, 4'd5, 8'hFF, 16'h0010, 16'h0020, 24'h123456));
    send_word(make_req(REQ_DRAW, 8'h3C, 4'd7, 8'h00, 16'h8000, 16'h7FFF, 24'hA5C3E1));
  endtask

  // Largest offsets, saturated scale three and scale zero
  task automatic test_scale_extremes();
    apply_config(3'd7, 16'hFFFF, 2'd2, 4'd8);
    send_word(make_req(REQ_DRAW, 8'd0, 4'd0, 8'h00, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
    send_word(make_req(REQ_DRAW, 8'd255, 4'd15, 8'h00, 16'hFFFF, 16'hFFFF, 24'h0F0F0F));
    apply_config(3'd4, 16'd4096, 2'd3, 4'd8);
    send_word(make_req(REQ_DRAW, 8'd0, 4'd0, 8'h00, 16'd100, 16'd200, 24'hF0E0D0));
    apply_config(3'd1, 16'd0, 2'd0, 4'd8);
    send_word(make_req(REQ_DRAW, 8'd0, 4'd0, 8'h00, 16'd5, 16'd6, 24'h00FF00));
  endtask

  // Zero width, widths above eight, single-column rows, odd pixel sizes
  task automatic test_width_extremes();
    apply_config(3'd0, 16'd640, 2'd1, 4'd0);
    send_word(make_req(REQ_DRAW, 8'd0, 4'd0, 8'h00, 16'd7, 16'd9, 24'hFF0000));
    apply_config(3'd5, 16'd1, 2'd2, 4'd15);
    send_word(make_req(REQ_DRAW, 8'd0, 4'd0, 8'h00, 16'd1, 16'd1, 24'h0000FF));
    send_word(make_req(REQ_DRAW, 8'd255, 4'd15, 8'h00, 16'hFFFE, 16'd3, 24'h808080));
    apply_config(3'd6, 16'd320, 2'd1, 4'd1);
    send_word(make_req(REQ_DRAW, 8'd255, 4'd15, 8'h00, 16'd50, 16'd60, 24'h7F7F7F));
    send_word(make_req(REQ_DRAW, 8'h3C, 4'd7, 8'h00, 16'd0, 16'hFFFF, 24'h010203));
  endtask

  // Random settings; mostly draws of loaded rows mixed with fresh loads
  task automatic test_random_mix();
    glyph_req_t  r;
    int unsigned key;
    logic [1:0]  scale;
    logic [3:0]  width;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      scale = ($urandom_range(0, 9) < 7) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
      width = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
      apply_config(3'($urandom_range(0, 7)), 16'($urandom), scale, width);
      for (int i = 0; i < WordsPerPhase; i++) begin
        r = make_req(REQ_LOAD, 8'($urandom), 4'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom), 24'($urandom));
        if (loaded_keys.size() != 0 && $urandom_range(0, 99) < 65) begin
          // draw only rows that hold a loaded bitmap
          key    = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
          r.kind = REQ_DRAW;
          r.code = key[11:4];
          r.row  = key[3:0];
        end
        send_word(r);
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_addr_i       <= CFG_BPP;
    cfg_wdata_i      <= '0;
    start            <= 1'b0;
    req_type_i       <= REQ_LOAD;
    character_code_i <= '0;
    glyph_row_i      <= '0;
    row_bits_i       <= '0;
    origin_x_i       <= '0;
    origin_y_i       <= '0;
    draw_color_i     <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_geometry();
    test_scale_extremes();
    test_width_extremes();
    test_random_mix();

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/grpr_pkg.sv
sv/grpr_ctrl.sv
sv/grpr_datapath.sv
sv/glyph_row_pixel_rasterizer.sv
sv/grpr_checker.sv
tb/glyph_row_pixel_rasterizer_test.sv
